>>> design/icm_pkg.sv
// Package for the iSLIP crossbar matcher: port count, field widths,
// request and match structs, pointer wrap function. No dependencies.
package icm_pkg;

  localparam int PORTS        = 8;
  localparam int IDX_W        = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int VALID_W      = 8;
  localparam int DEST_W       = 3;
  localparam int DEST_FIELD_W = VALID_W * DEST_W;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [PORTS-1:0]             valid;
    logic [PORTS-1:0][DEST_W-1:0] dest;
  } req_t;

  typedef struct packed {
    logic [PORTS-1:0] served;
    logic [PORTS-1:0] matched;
    idx_t [PORTS-1:0] source;
  } match_t;

  function automatic idx_t wrap_next(idx_t x);
    return (x == idx_t'(PORTS - 1)) ? '0 : x + idx_t'(1);
  endfunction

endpackage

>>> design/islip_crossbar_matcher.sv
// Top level of the iSLIP crossbar matcher: input register, match core,
// result register and handshake. Depends on icm_pkg and icm_match_core.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   request_valid_i, request_dest_i
//   out      output     out_valid_o/out_ready_i input_served_o, output_matched_o,
//                                               output_source_o
//
// One transfer per cycle sustained unless the result stalls; path to result
// valid: input register, one pass of grant and accept arbiters, result
// register. Grant pointers update with each result, so back-to-back items see
// the previous item's pointers. Reset clears both valids and all pointers to
// zero. A stalled result holds; one more item waits in the input register.
module islip_crossbar_matcher (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [icm_pkg::VALID_W-1:0]         request_valid_i,
  input  logic [icm_pkg::DEST_FIELD_W-1:0]    request_dest_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [icm_pkg::VALID_W-1:0]         input_served_o,
  output logic [icm_pkg::VALID_W-1:0]         output_matched_o,
  output logic [icm_pkg::DEST_FIELD_W-1:0]    output_source_o
);

  logic                             in_valid_q, in_valid_d;
  logic [icm_pkg::VALID_W-1:0]      req_valid_q;
  logic [icm_pkg::DEST_FIELD_W-1:0] req_dest_q;
  logic                             out_valid_q, out_valid_d;
  logic [icm_pkg::VALID_W-1:0]      served_q, served_d;
  logic [icm_pkg::VALID_W-1:0]      matched_q, matched_d;
  logic [icm_pkg::DEST_FIELD_W-1:0] source_q, source_d;

  logic            advance;
  logic            in_xfer;
  icm_pkg::req_t   req;
  icm_pkg::match_t match;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  for (genvar p = 0; p < icm_pkg::PORTS; p++) begin : g_req
    if (p < icm_pkg::VALID_W) begin : g_in
      assign req.valid[p] = req_valid_q[p];
      assign req.dest[p]  = req_dest_q[p*icm_pkg::DEST_W +: icm_pkg::DEST_W];
    end else begin : g_none
      assign req.valid[p] = 1'b0;
      assign req.dest[p]  = '0;
    end
  end

  icm_match_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (req),
    .match_o   (match)
  );

  for (genvar k = 0; k < icm_pkg::VALID_W; k++) begin : g_res
    if (k < icm_pkg::PORTS) begin : g_port
      assign served_d[k]  = match.served[k];
      assign matched_d[k] = match.matched[k];
      assign source_d[k*icm_pkg::DEST_W +: icm_pkg::DEST_W] =
        icm_pkg::DEST_W'(match.source[k]);
    end else begin : g_pad
      assign served_d[k]  = 1'b0;
      assign matched_d[k] = 1'b0;
      assign source_d[k*icm_pkg::DEST_W +: icm_pkg::DEST_W] = '0;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_valid_q <= request_valid_i;
      req_dest_q  <= request_dest_i;
    end
    if (advance) begin
      served_q  <= served_d;
      matched_q <= matched_d;
      source_q  <= source_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign input_served_o   = served_q;
  assign output_matched_o = matched_q;
  assign output_source_o  = source_q;

  a_match_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones(served_q) == $countones(matched_q)))
    else $error("served inputs and matched outputs differ in count");

  a_served_requested : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ((served_q & ~$past(req_valid_q)) == '0))
    else $error("input served without a request");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input not ready with empty input register");

endmodule

>>> design/icm_rr_arb.sv
// Round-robin programmable priority arbiter over PORTS requesters.
// Depends on icm_pkg.
module icm_rr_arb (
  input  logic [icm_pkg::PORTS-1:0] req_i,
  input  icm_pkg::idx_t             ptr_i,
  output logic [icm_pkg::PORTS-1:0] gnt_o,
  output logic                      any_o,
  output icm_pkg::idx_t             idx_o
);

  always_comb begin
    logic [icm_pkg::PORTS-1:0] upper;
    upper = '0;
    for (int k = 0; k < icm_pkg::PORTS; k++) begin
      upper[k] = req_i[k] && (k >= int'(ptr_i));
    end
    idx_o = '0;
    for (int k = icm_pkg::PORTS - 1; k >= 0; k--) begin
      if (req_i[k]) begin
        idx_o = icm_pkg::idx_t'(k);
      end
    end
    // requests at or after the pointer win over the wrapped ones
    for (int k = icm_pkg::PORTS - 1; k >= 0; k--) begin
      if (upper[k]) begin
        idx_o = icm_pkg::idx_t'(k);
      end
    end
    any_o = |req_i;
    gnt_o = '0;
    if (any_o) begin
      gnt_o[idx_o] = 1'b1;
    end
  end

endmodule

>>> design/icm_match_core.sv
// Grant and accept arbiter arrays with grant and accept pointer registers.
// Depends on icm_pkg and icm_rr_arb.
module icm_match_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  icm_pkg::req_t    req_i,
  output icm_pkg::match_t  match_o
);

  icm_pkg::idx_t [icm_pkg::PORTS-1:0] grant_ptr_q, grant_ptr_d;
  icm_pkg::idx_t [icm_pkg::PORTS-1:0] accept_ptr_q, accept_ptr_d;

  logic [icm_pkg::PORTS-1:0][icm_pkg::PORTS-1:0] grant_req;
  logic [icm_pkg::PORTS-1:0][icm_pkg::PORTS-1:0] grant_vec;
  logic [icm_pkg::PORTS-1:0]                     grant_any;
  icm_pkg::idx_t [icm_pkg::PORTS-1:0]            grant_idx;

  logic [icm_pkg::PORTS-1:0][icm_pkg::PORTS-1:0] offer;
  logic [icm_pkg::PORTS-1:0][icm_pkg::PORTS-1:0] accept_vec;
  logic [icm_pkg::PORTS-1:0]                     accept_any;
  icm_pkg::idx_t [icm_pkg::PORTS-1:0]            accept_idx;

  always_comb begin
    for (int o = 0; o < icm_pkg::PORTS; o++) begin
      for (int i = 0; i < icm_pkg::PORTS; i++) begin
        grant_req[o][i] = req_i.valid[i] && (int'(req_i.dest[i]) == o);
        offer[i][o]     = grant_vec[o][i];
      end
    end
  end

  for (genvar g = 0; g < icm_pkg::PORTS; g++) begin : g_arb
    icm_rr_arb u_grant (
      .req_i (grant_req[g]),
      .ptr_i (grant_ptr_q[g]),
      .gnt_o (grant_vec[g]),
      .any_o (grant_any[g]),
      .idx_o (grant_idx[g])
    );

    icm_rr_arb u_accept (
      .req_i (offer[g]),
      .ptr_i (accept_ptr_q[g]),
      .gnt_o (accept_vec[g]),
      .any_o (accept_any[g]),
      .idx_o (accept_idx[g])
    );
  end

  always_comb begin
    logic col;
    match_o.served = accept_any;
    for (int o = 0; o < icm_pkg::PORTS; o++) begin
      col = 1'b0;
      for (int i = 0; i < icm_pkg::PORTS; i++) begin
        col = col | accept_vec[i][o];
      end
      match_o.matched[o] = grant_any[o] && col;
      match_o.source[o]  = match_o.matched[o] ? grant_idx[o] : '0;
    end
  end

  always_comb begin
    grant_ptr_d  = grant_ptr_q;
    accept_ptr_d = accept_ptr_q;
    for (int k = 0; k < icm_pkg::PORTS; k++) begin
      if (accept_any[k]) begin
        accept_ptr_d[k] = icm_pkg::wrap_next(accept_idx[k]);
      end
      if (match_o.matched[k]) begin
        grant_ptr_d[k] = icm_pkg::wrap_next(grant_idx[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grant_ptr_q  <= '0;
      accept_ptr_q <= '0;
    end else if (advance_i) begin
      grant_ptr_q  <= grant_ptr_d;
      accept_ptr_q <= accept_ptr_d;
    end
  end

endmodule
